// File: hdl/brls_pkg.sv
// Shared constants, types and codes for the bit run length statistics block.
package brls_pkg;

  localparam int unsigned MAX_SEQ_BITS = 1048576;
  localparam int unsigned BITS_W       = $clog2(MAX_SEQ_BITS + 1);
  localparam int unsigned COUNT_W      = 20;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned VALUE_W      = 29;
  localparam int unsigned DIV_STEPS    = VALUE_W;
  localparam int unsigned STEP_W       = $clog2(DIV_STEPS);
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_W       = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_MEAN  = 2'd1,
    KIND_MAX   = 2'd2,
    KIND_MIN   = 2'd3
  } stat_kind_t;

  typedef enum logic {
    REG_MATCH_BIT   = 1'b0,
    REG_STAT_SELECT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } back_state_t;

  // one classified byte: leading run, runs closed inside the byte, trailing run
  typedef struct packed {
    logic [3:0] lead;
    logic       brk;
    logic [2:0] icnt;
    logic [3:0] isum;
    logic [2:0] imax;
    logic [2:0] imin;
    logic [2:0] tail;
    logic [3:0] nbits;
    logic       last;
  } brls_word_t;

endpackage

// File: hdl/brls_front.sv
// Front end: accepts bytes, clamps the bit count and splits each byte into runs.
module brls_front import brls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       match_bit,
  input  logic [7:0] data_byte,
  input  logic [3:0] valid_bits,
  input  logic       last_byte,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output brls_word_t q_word
);

  logic [BITS_W-1:0] bits_seen;
  logic [BITS_W-1:0] bits_seen_next;
  logic [BITS_W-1:0] room;
  logic [3:0]        n_req;
  logic [3:0]        n_eff;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    n_req = (valid_bits > 4'd8) ? 4'd8 : valid_bits;
    room  = BITS_W'(MAX_SEQ_BITS) - bits_seen;
    n_eff = (room < BITS_W'(n_req)) ? room[3:0] : n_req;
  end

  always_comb begin
    logic [3:0] run;
    logic       brk;
    logic [2:0] icnt;
    logic [3:0] isum;
    logic [2:0] imax;
    logic [2:0] imin;
    logic [3:0] lead;
    logic [2:0] tail;
    run  = '0;
    brk  = 1'b0;
    icnt = '0;
    isum = '0;
    imax = '0;
    imin = '1;
    lead = '0;
    tail = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n_eff) begin
        if (data_byte[7-i] == match_bit) begin
          run = run + 4'd1;
        end else begin
          if (!brk) begin
            lead = run;
          end else if (run != 4'd0) begin
            icnt = icnt + 3'd1;
            isum = isum + run;
            if (run[2:0] > imax) imax = run[2:0];
            if (run[2:0] < imin) imin = run[2:0];
          end
          brk = 1'b1;
          run = '0;
        end
      end
    end
    if (!brk) begin
      lead = run;
    end else if (last_byte && run != 4'd0) begin
      // final trailing run closes inside the byte
      icnt = icnt + 3'd1;
      isum = isum + run;
      if (run[2:0] > imax) imax = run[2:0];
      if (run[2:0] < imin) imin = run[2:0];
    end else begin
      tail = run[2:0];
    end
    q_word.lead  = lead;
    q_word.brk   = brk;
    q_word.icnt  = icnt;
    q_word.isum  = isum;
    q_word.imax  = imax;
    q_word.imin  = imin;
    q_word.tail  = tail;
    q_word.nbits = n_eff;
    q_word.last  = last_byte;
  end

  always_comb begin
    bits_seen_next = bits_seen;
    if (q_push) begin
      bits_seen_next = last_byte ? '0 : bits_seen + BITS_W'(n_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_seen <= '0;
    end else begin
      bits_seen <= bits_seen_next;
    end
  end

endmodule

// File: hdl/brls_fifo.sv
// Short queue of classified words between front and back.
module brls_fifo import brls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  brls_word_t word_in,
  output logic       full,
  input  logic       pop,
  output brls_word_t word_out,
  output logic       empty
);

  brls_word_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full     = (fill == (QPTR_W + 1)'(QDEPTH));
  assign empty    = (fill == '0);
  assign word_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= word_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: hdl/brls_div.sv
// Restoring divider, one quotient bit per cycle, for the mean.
module brls_div import brls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [COUNT_W-1:0] divisor,
  output logic               busy,
  output logic [VALUE_W-1:0] quotient
);

  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] rem_next;
  logic [COUNT_W-1:0] dvsr;
  logic [VALUE_W-1:0] quo;
  logic [STEP_W-1:0]  step;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               ge;

  assign quotient = quo;

  always_comb begin
    trial    = {rem, quo[VALUE_W-1]};
    diff     = trial - {1'b0, dvsr};
    ge       = (trial >= {1'b0, dvsr});
    rem_next = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem  <= rem_next;
      quo  <= {quo[VALUE_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(DIV_STEPS - 1)) busy <= 1'b0;
    end
  end

endmodule

// File: hdl/brls_back.sv
// Back end: merges run summaries into the statistics and emits the selected results.
module brls_back import brls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [3:0]         stat_select,
  input  logic               q_empty,
  input  brls_word_t         q_word,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         stat_kind,
  output logic [VALUE_W-1:0] stat_value,
  output logic               mean_undefined,
  output logic               last_stat
);

  back_state_t        state, state_next;
  logic [1:0]         kidx;

  logic [BITS_W-1:0]  open_len, open_len_next;
  logic [COUNT_W-1:0] run_count, run_count_next;
  logic [BITS_W-1:0]  len_sum, len_sum_next;
  logic [BITS_W-1:0]  longest, longest_next;
  logic [BITS_W-1:0]  shortest, shortest_next;
  logic [BITS_W-1:0]  bits_seen, bits_seen_next;

  logic [3:0]         sel;
  logic [BITS_W-1:0]  open_lead;
  logic [BITS_W-1:0]  a_len;
  logic               a_nz;
  logic [COUNT_W-1:0] count_m;
  logic [BITS_W-1:0]  sum_m;
  logic [BITS_W-1:0]  longest_m;
  logic [BITS_W-1:0]  shortest_m;
  logic [BITS_W-1:0]  open_m;

  logic               div_start;
  logic               div_busy;
  logic [VALUE_W-1:0] div_quo;
  logic               slot_free;
  logic               emit;
  logic               advance;
  logic               finish;

  stat_kind_t         kind;
  logic [VALUE_W-1:0] value_sel;
  logic               last_sel;

  assign sel = (stat_select == 4'd0) ? 4'b0001 : stat_select;

  // merge of one queue word
  always_comb begin
    open_lead = open_len + BITS_W'(q_word.lead);
    a_len     = (q_word.brk || q_word.last) ? open_lead : '0;
    a_nz      = (a_len != '0);
    count_m   = run_count + COUNT_W'(a_nz) + COUNT_W'(q_word.icnt);
    sum_m     = len_sum + a_len + BITS_W'(q_word.isum);
    longest_m = longest;
    if (a_len > longest_m) longest_m = a_len;
    if (BITS_W'(q_word.imax) > longest_m) longest_m = BITS_W'(q_word.imax);
    shortest_m = shortest;
    if (a_nz && a_len < shortest_m) shortest_m = a_len;
    if (q_word.icnt != 3'd0 && BITS_W'(q_word.imin) < shortest_m) begin
      shortest_m = BITS_W'(q_word.imin);
    end
    if (q_word.last) begin
      open_m = '0;
    end else if (q_word.brk) begin
      open_m = BITS_W'(q_word.tail);
    end else begin
      open_m = open_lead;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (!q_empty && q_word.last) begin
          state_next = (sel[1] && count_m != '0) ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (!div_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (finish) state_next = ST_RUN;
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    slot_free = !out_valid || out_ready;
    q_pop     = (state == ST_RUN) && !q_empty;
    div_start = q_pop && q_word.last && sel[1] && (count_m != '0);
    emit      = (state == ST_EMIT) && sel[kidx] && slot_free;
    advance   = (state == ST_EMIT) && (!sel[kidx] || slot_free);
    finish    = advance && (kidx == 2'd3);
  end

  always_comb begin
    open_len_next  = open_len;
    run_count_next = run_count;
    len_sum_next   = len_sum;
    longest_next   = longest;
    shortest_next  = shortest;
    bits_seen_next = bits_seen;
    if (q_pop) begin
      open_len_next  = open_m;
      run_count_next = count_m;
      len_sum_next   = sum_m;
      longest_next   = longest_m;
      shortest_next  = shortest_m;
      bits_seen_next = bits_seen + BITS_W'(q_word.nbits);
    end else if (finish) begin
      open_len_next  = '0;
      run_count_next = '0;
      len_sum_next   = '0;
      longest_next   = '0;
      shortest_next  = '1;
      bits_seen_next = '0;
    end
  end

  always_comb begin
    kind = stat_kind_t'(kidx);
    unique case (kind)
      KIND_COUNT: value_sel = VALUE_W'(run_count);
      KIND_MEAN:  value_sel = (run_count == '0) ? '0 : div_quo;
      KIND_MAX:   value_sel = VALUE_W'(longest);
      KIND_MIN:   value_sel = (run_count == '0) ? VALUE_W'(bits_seen) : VALUE_W'(shortest);
      default:    value_sel = '0;
    endcase
    unique case (kind)
      KIND_COUNT: last_sel = (sel[3:1] == 3'd0);
      KIND_MEAN:  last_sel = (sel[3:2] == 2'd0);
      KIND_MAX:   last_sel = !sel[3];
      KIND_MIN:   last_sel = 1'b1;
      default:    last_sel = 1'b1;
    endcase
  end

  brls_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (VALUE_W'({sum_m, {FRAC_BITS{1'b0}}})),
    .divisor  (count_m),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      kidx      <= '0;
      out_valid <= 1'b0;
      open_len  <= '0;
      run_count <= '0;
      len_sum   <= '0;
      longest   <= '0;
      shortest  <= '1;
      bits_seen <= '0;
    end else begin
      state     <= state_next;
      open_len  <= open_len_next;
      run_count <= run_count_next;
      len_sum   <= len_sum_next;
      longest   <= longest_next;
      shortest  <= shortest_next;
      bits_seen <= bits_seen_next;
      if (advance) kidx <= kidx + 2'd1;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      stat_kind      <= kind;
      stat_value     <= value_sel;
      mean_undefined <= (kind == KIND_MEAN) && (run_count == '0);
      last_stat      <= last_sel;
    end
  end

  a_div_needs_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (run_count != '0))
    else $error("divide started with no runs");

  a_open_within_bits: assert property (@(posedge clk) disable iff (rst)
    open_len <= bits_seen)
    else $error("open run longer than bits seen");

  a_short_le_long: assert property (@(posedge clk) disable iff (rst)
    (run_count != '0) |-> (shortest <= longest))
    else $error("shortest run above longest run");

endmodule

// File: hdl/bit_run_length_statistics.sv
// Top level of the bit run length statistics block: register port, front, queue, back.
//
//  port group   dir   word / access
//  in_*         in    data_byte, valid_bits, last_byte; valid/ready
//  out_*        out   stat_kind, stat_value, mean_undefined, last_stat; valid/ready
//  apb          in    match_bit at 0x0, stat_select at 0x4; pready tied high
//
// One byte accepted per cycle while the four-word queue has room; the back merges
// one queued word per cycle while in its run state. After a last byte: a merge, a
// divide when the mean is selected and runs exist, then four emit steps, each selected
// word waiting on out_ready. Synchronous active-high reset clears all statistics.
// Either side may stall; the queue and the output register hold words meanwhile.
module bit_run_length_statistics import brls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic [7:0]         data_byte,
  input  logic [3:0]         valid_bits,
  input  logic               last_byte,
  input  logic               in_valid,
  output logic               in_ready,
  output logic [1:0]         stat_kind,
  output logic [VALUE_W-1:0] stat_value,
  output logic               mean_undefined,
  output logic               last_stat,
  output logic               out_valid,
  input  logic               out_ready
);

  logic       match_bit;
  logic [3:0] stat_select;
  logic       wr_en;
  reg_idx_t   reg_idx;

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  brls_word_t q_in;
  brls_word_t q_out;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      REG_MATCH_BIT:   prdata = {31'd0, match_bit};
      REG_STAT_SELECT: prdata = {28'd0, stat_select};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_bit   <= 1'b1;
      stat_select <= 4'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MATCH_BIT:   match_bit   <= pwdata[0];
        REG_STAT_SELECT: stat_select <= pwdata[3:0];
        default:         ;
      endcase
    end
  end

  brls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .match_bit  (match_bit),
    .data_byte  (data_byte),
    .valid_bits (valid_bits),
    .last_byte  (last_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_word     (q_in)
  );

  brls_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .word_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .word_out (q_out),
    .empty    (q_empty)
  );

  brls_back u_back (
    .clk            (clk),
    .rst            (rst),
    .stat_select    (stat_select),
    .q_empty        (q_empty),
    .q_word         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .stat_kind      (stat_kind),
    .stat_value     (stat_value),
    .mean_undefined (mean_undefined),
    .last_stat      (last_stat)
  );

endmodule
